[hdl/hbc_pkg.sv]
// shared constants, codes and helpers of the hashed block buffer cache
`timescale 1ns / 1ps
`default_nettype none
package hbc_pkg;

    localparam int POOL_SIZE    = 32;
    localparam int BUCKET_COUNT = 13;
    localparam int IDX_W        = $clog2(POOL_SIZE);
    localparam int LINK_W       = 6;
    localparam int BKT_W        = $clog2(BUCKET_COUNT);
    localparam int STEP_W       = $clog2(POOL_SIZE + 1);
    localparam int COUNT_W      = 8;
    localparam int DEV_W        = 8;
    localparam int BLK_W        = 32;
    localparam int DIGIT_W      = 2;
    localparam int HASH_STEPS   = BLK_W / DIGIT_W;
    localparam int HSTEP_W      = $clog2(HASH_STEPS);

    localparam logic [LINK_W-1:0]  NO_LINK   = 6'd63;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        KIND_ACQUIRE = 2'd0,
        KIND_ADD_REF = 2'd1,
        KIND_DROP_REF = 2'd2,
        KIND_UNUSED  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ALLOC   = 2'd1,
        ST_NO_FREE = 2'd2,
        ST_CNT_ERR = 2'd3
    } status_t;

    // one reduction step: value below 4 * BUCKET_COUNT back into 0 .. BUCKET_COUNT-1
    function automatic logic [BKT_W-1:0] bucket_reduce(input logic [BKT_W+DIGIT_W-1:0] v);
        logic [BKT_W+DIGIT_W-1:0] r;
        r = v;
        for (int k = 0; k < 3; k++) begin
            if (r >= (BKT_W+DIGIT_W)'(BUCKET_COUNT)) begin
                r = r - (BKT_W+DIGIT_W)'(BUCKET_COUNT);
            end
        end
        return r[BKT_W-1:0];
    endfunction

endpackage
`default_nettype wire

[hdl/hbc_hash.sv]
// block number to bucket reduction, two bits per cycle from the top
`timescale 1ns / 1ps
`default_nettype none
module hbc_hash (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [hbc_pkg::BLK_W-1:0] value,
    output logic                           done,
    output logic [hbc_pkg::BKT_W-1:0]      bucket
);
    import hbc_pkg::*;

    logic [BLK_W-1:0]   val_reg;
    logic [BKT_W-1:0]   rem_reg;
    logic [HSTEP_W-1:0] cnt_reg;
    logic               run_reg;
    logic               done_reg;

    // shift digits in and keep the running remainder
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                val_reg <= value;
                rem_reg <= '0;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end else if (run_reg) begin
                rem_reg <= bucket_reduce({rem_reg, val_reg[BLK_W-1 -: DIGIT_W]});
                val_reg <= val_reg << DIGIT_W;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == HSTEP_W'(HASH_STEPS - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign bucket = rem_reg;

endmodule
`default_nettype wire

[hdl/hashed_block_buffer_cache_unit.sv]
// top level of the hashed block buffer cache: pool state, list walker and result register
//
// channel | dir | tdata (low bit up)                          | tuser
// s_      | in  | device_id[7:0] block_number[39:8] buffer_index[44:40], zero pad | kind[1:0]
// m_      | out | slot[4:0] status[6:5] fill_needed[7]         | -
//
// acquire: the bucket reduction and a load of the home bucket head, then a walk over the
// entries of the home bucket; on a miss, per bucket scanned a load of its tail and a walk
// toward the head; a free buffer found in another bucket is unlinked and pushed to the
// head of the home bucket, then the result is presented. add and drop adjust the count,
// an unknown kind goes straight to the result. one transfer is worked at a time.
// aresetn is synchronous; reset puts every buffer in bucket 0, tagged device 0 block 0, not valid and free.
// a result held on m_ by a low m_tready stalls the next item only at its final step.
`timescale 1ns / 1ps
`default_nettype none
module hashed_block_buffer_cache_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // device_id, block_number, buffer_index
    input  wire logic [1:0]  s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // slot, status, fill_needed
);
    import hbc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_HASH, S_HIT_LOAD, S_HIT, S_FREE_LOAD, S_FREE,
        S_UNLINK, S_PUSH, S_ADJ, S_DONE
    } state_t;

    state_t state_reg;

    // pool state
    logic [DEV_W-1:0]   tag_device_reg [POOL_SIZE];
    logic [BLK_W-1:0]   tag_block_reg  [POOL_SIZE];
    logic               valid_reg      [POOL_SIZE];
    logic [COUNT_W-1:0] count_reg      [POOL_SIZE];
    logic [LINK_W-1:0]  next_link_reg  [POOL_SIZE];
    logic [LINK_W-1:0]  prev_link_reg  [POOL_SIZE];
    logic [LINK_W-1:0]  first_reg      [BUCKET_COUNT];
    logic [LINK_W-1:0]  last_reg       [BUCKET_COUNT];

    // walker and request
    logic [LINK_W-1:0] b_reg;
    logic [STEP_W-1:0] steps_reg;
    logic [BKT_W-1:0]  t_reg;
    logic [BKT_W-1:0]  h_reg;
    logic [BKT_W-1:0]  i_reg;
    kind_t             kind_reg;
    logic [DEV_W-1:0]  dev_reg;
    logic [BLK_W-1:0]  blk_reg;

    // pending and presented result
    logic [IDX_W-1:0] res_slot_reg;
    status_t          res_status_reg;
    logic             res_fill_reg;
    logic             m_valid_reg;
    logic [7:0]       m_data_reg;

    logic              hash_start;
    logic              hash_done;
    logic [BKT_W-1:0]  hash_bucket;
    logic              s_xfer;
    logic              b_ok;
    logic [IDX_W-1:0]  bi;
    logic              tag_hit;
    logic [LINK_W-1:0] lp;
    logic [LINK_W-1:0] ln;
    logic [LINK_W-1:0] lf;

    hbc_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .value   (s_tdata[DEV_W +: BLK_W]),
        .done    (hash_done),
        .bucket  (hash_bucket)
    );

    assign s_tready   = (state_reg == S_IDLE);
    assign s_xfer     = s_tvalid && s_tready;
    assign hash_start = s_xfer && (kind_t'(s_tuser) == KIND_ACQUIRE);

    // walker view of the current entry
    assign b_ok    = (b_reg < LINK_W'(POOL_SIZE)) && (steps_reg < STEP_W'(POOL_SIZE));
    assign bi      = b_reg[IDX_W-1:0];
    assign tag_hit = (tag_device_reg[bi] == dev_reg) && (tag_block_reg[bi] == blk_reg);
    assign lp      = prev_link_reg[bi];
    assign ln      = next_link_reg[bi];
    assign lf      = first_reg[t_reg];

    // sequencer, pool state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < POOL_SIZE; k++) begin
                tag_device_reg[k] <= '0;
                tag_block_reg[k]  <= '0;
                valid_reg[k]      <= 1'b0;
                count_reg[k]      <= '0;
                next_link_reg[k]  <= (k == 0) ? NO_LINK : LINK_W'(k - 1);
                prev_link_reg[k]  <= (k == POOL_SIZE - 1) ? NO_LINK : LINK_W'(k + 1);
            end
            for (int k = 0; k < BUCKET_COUNT; k++) begin
                first_reg[k] <= (k == 0) ? LINK_W'(POOL_SIZE - 1) : NO_LINK;
                last_reg[k]  <= (k == 0) ? LINK_W'(0) : NO_LINK;
            end
        end else begin
            if (m_valid_reg && m_tready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_xfer) begin
                        kind_reg <= kind_t'(s_tuser);
                        dev_reg  <= s_tdata[DEV_W-1:0];
                        blk_reg  <= s_tdata[DEV_W +: BLK_W];
                        b_reg    <= {1'b0, s_tdata[DEV_W+BLK_W +: IDX_W]};
                        unique case (kind_t'(s_tuser))
                            KIND_ACQUIRE: state_reg <= S_HASH;
                            KIND_ADD_REF, KIND_DROP_REF: state_reg <= S_ADJ;
                            default: begin
                                res_slot_reg   <= '0;
                                res_status_reg <= ST_CNT_ERR;
                                res_fill_reg   <= 1'b0;
                                state_reg      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        h_reg     <= hash_bucket;
                        t_reg     <= hash_bucket;
                        state_reg <= S_HIT_LOAD;
                    end
                end
                S_HIT_LOAD: begin
                    b_reg     <= first_reg[t_reg];
                    steps_reg <= '0;
                    state_reg <= S_HIT;
                end
                // look for a matching tag in the home bucket
                S_HIT: begin
                    if (!b_ok) begin
                        i_reg     <= '0;
                        state_reg <= S_FREE_LOAD;
                    end else if (tag_hit) begin
                        res_slot_reg <= bi;
                        if (count_reg[bi] >= COUNT_MAX) begin
                            res_status_reg <= ST_CNT_ERR;
                            res_fill_reg   <= 1'b0;
                        end else begin
                            count_reg[bi]  <= count_reg[bi] + 1'b1;
                            valid_reg[bi]  <= 1'b1;
                            res_status_reg <= ST_OK;
                            res_fill_reg   <= !valid_reg[bi];
                        end
                        state_reg <= S_DONE;
                    end else begin
                        b_reg     <= ln;
                        steps_reg <= steps_reg + 1'b1;
                    end
                end
                S_FREE_LOAD: begin
                    b_reg     <= last_reg[t_reg];
                    steps_reg <= '0;
                    state_reg <= S_FREE;
                end
                // scan buckets from their tails for a free buffer
                S_FREE: begin
                    if (!b_ok) begin
                        if (i_reg == BKT_W'(BUCKET_COUNT - 1)) begin
                            res_slot_reg   <= '0;
                            res_status_reg <= ST_NO_FREE;
                            res_fill_reg   <= 1'b0;
                            state_reg      <= S_DONE;
                        end else begin
                            i_reg     <= i_reg + 1'b1;
                            t_reg     <= (t_reg == BKT_W'(BUCKET_COUNT - 1)) ? '0
                                                                             : t_reg + 1'b1;
                            state_reg <= S_FREE_LOAD;
                        end
                    end else if (count_reg[bi] == '0) begin
                        tag_device_reg[bi] <= dev_reg;
                        tag_block_reg[bi]  <= blk_reg;
                        count_reg[bi]      <= COUNT_W'(1);
                        valid_reg[bi]      <= 1'b1;
                        res_slot_reg       <= bi;
                        res_status_reg     <= ST_ALLOC;
                        res_fill_reg       <= 1'b1;
                        state_reg          <= (t_reg != h_reg) ? S_UNLINK : S_DONE;
                    end else begin
                        b_reg     <= lp;
                        steps_reg <= steps_reg + 1'b1;
                    end
                end
                // take the buffer out of its old bucket
                S_UNLINK: begin
                    if (lp < LINK_W'(POOL_SIZE)) begin
                        next_link_reg[lp[IDX_W-1:0]] <= ln;
                    end else begin
                        first_reg[t_reg] <= ln;
                    end
                    if (ln < LINK_W'(POOL_SIZE)) begin
                        prev_link_reg[ln[IDX_W-1:0]] <= lp;
                    end else begin
                        last_reg[t_reg] <= lp;
                    end
                    t_reg     <= h_reg;
                    state_reg <= S_PUSH;
                end
                // put it at the head of the home bucket
                S_PUSH: begin
                    next_link_reg[bi] <= lf;
                    prev_link_reg[bi] <= NO_LINK;
                    if (lf < LINK_W'(POOL_SIZE)) begin
                        prev_link_reg[lf[IDX_W-1:0]] <= b_reg;
                    end else begin
                        last_reg[t_reg] <= b_reg;
                    end
                    first_reg[t_reg] <= b_reg;
                    state_reg        <= S_DONE;
                end
                // add or drop one reference
                S_ADJ: begin
                    res_slot_reg <= bi;
                    res_fill_reg <= 1'b0;
                    if (b_reg >= LINK_W'(POOL_SIZE)) begin
                        res_status_reg <= ST_CNT_ERR;
                    end else if (kind_reg == KIND_ADD_REF) begin
                        if (count_reg[bi] >= COUNT_MAX) begin
                            res_status_reg <= ST_CNT_ERR;
                        end else begin
                            count_reg[bi]  <= count_reg[bi] + 1'b1;
                            res_status_reg <= ST_OK;
                        end
                    end else begin
                        if (count_reg[bi] == '0) begin
                            res_status_reg <= ST_CNT_ERR;
                        end else begin
                            count_reg[bi]  <= count_reg[bi] - 1'b1;
                            res_status_reg <= ST_OK;
                        end
                    end
                    state_reg <= S_DONE;
                end
                // hand the result to the output register once it is free
                S_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {res_fill_reg, res_status_reg, res_slot_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

[dv/tb_hashed_block_buffer_cache_unit.sv]
// testbench of the hashed block buffer cache: directed and random requests against a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_hashed_block_buffer_cache_unit;
    import hbc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic       fill_needed;
        status_t    status;
        logic [4:0] slot;
    } grant_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;

    hashed_block_buffer_cache_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // predictor state of the buffer pool
    logic [7:0]  pool_dev   [POOL_SIZE];
    logic [31:0] pool_blk   [POOL_SIZE];
    logic        pool_valid [POOL_SIZE];
    logic [7:0]  pool_refs  [POOL_SIZE];
    logic [5:0]  link_next  [POOL_SIZE];
    logic [5:0]  link_prev  [POOL_SIZE];
    logic [5:0]  chain_head [BUCKET_COUNT];
    logic [5:0]  chain_tail [BUCKET_COUNT];

    grant_t pending_grants[$];
    int     fail_count;
    int     grants_seen;
    int     idle_cycles;
    bit     sink_stalls;
    bit     source_gaps;
    int     allocs_seen, nofree_seen, errs_seen;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic void pool_reset();
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_dev[i] = '0;
            pool_blk[i] = '0;
            pool_valid[i] = 1'b0;
            pool_refs[i] = '0;
            link_next[i] = (i == 0) ? NO_LINK : 6'(i - 1);
            link_prev[i] = (i == POOL_SIZE - 1) ? NO_LINK : 6'(i + 1);
        end
        for (int k = 0; k < BUCKET_COUNT; k++) begin
            chain_head[k] = NO_LINK;
            chain_tail[k] = NO_LINK;
        end
        chain_head[0] = 6'(POOL_SIZE - 1);
        chain_tail[0] = '0;
    endfunction

    // move buffer b from bucket t to the head of bucket h
    function automatic void relink_to_head(int b, int t, int h);
        logic [5:0] p, n, f;
        p = link_prev[b];
        n = link_next[b];
        if (p < POOL_SIZE) link_next[p] = n; else chain_head[t] = n;
        if (n < POOL_SIZE) link_prev[n] = p; else chain_tail[t] = p;
        f = chain_head[h];
        link_next[b] = f;
        link_prev[b] = NO_LINK;
        if (f < POOL_SIZE) link_prev[f] = 6'(b); else chain_tail[h] = 6'(b);
        chain_head[h] = 6'(b);
    endfunction

    function automatic grant_t predict_grant(kind_t kind, logic [7:0] dev, logic [31:0] blk,
                                             logic [4:0] idx);
        grant_t g;
        int h, t, b, steps;
        g = '{slot: '0, status: ST_CNT_ERR, fill_needed: 1'b0};
        if (kind == KIND_ACQUIRE) begin
            h = int'(blk % BUCKET_COUNT);
            b = chain_head[h];
            steps = 0;
            // look for a tag hit in the home bucket
            while (b < POOL_SIZE && steps < POOL_SIZE) begin
                if (pool_dev[b] == dev && pool_blk[b] == blk) begin
                    g.slot = 5'(b);
                    if (pool_refs[b] == COUNT_MAX) return g;
                    pool_refs[b]++;
                    g.status = ST_OK;
                    g.fill_needed = ~pool_valid[b];
                    pool_valid[b] = 1'b1;
                    return g;
                end
                b = link_next[b];
                steps++;
            end
            // scan all buckets from the tail for a free buffer
            for (int i = 0; i < BUCKET_COUNT; i++) begin
                t = (h + i) % BUCKET_COUNT;
                b = chain_tail[t];
                steps = 0;
                while (b < POOL_SIZE && steps < POOL_SIZE) begin
                    if (pool_refs[b] == 0) begin
                        if (t != h) relink_to_head(b, t, h);
                        pool_dev[b] = dev;
                        pool_blk[b] = blk;
                        pool_refs[b] = 8'd1;
                        pool_valid[b] = 1'b1;
                        g.slot = 5'(b);
                        g.status = ST_ALLOC;
                        g.fill_needed = 1'b1;
                        return g;
                    end
                    b = link_prev[b];
                    steps++;
                end
            end
            g.status = ST_NO_FREE;
        end else if (kind == KIND_ADD_REF) begin
            g.slot = idx;
            if (pool_refs[idx] != COUNT_MAX) begin
                pool_refs[idx]++;
                g.status = ST_OK;
            end
        end else if (kind == KIND_DROP_REF) begin
            g.slot = idx;
            if (pool_refs[idx] != 0) begin
                pool_refs[idx]--;
                g.status = ST_OK;
            end
        end
        return g;
    endfunction

    // send one request and queue its expected grant
    task automatic send_request(kind_t kind, logic [7:0] dev, logic [31:0] blk, logic [4:0] idx);
        int gap;
        if (source_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b0, idx, blk, dev};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_grants.push_back(predict_grant(kind, dev, blk, idx));
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // result side: random stall bursts, checks each accepted grant
    initial begin
        grant_t want, got;
        int burst;
        m_tready = 1'b0;
        burst = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = grant_t'(m_tdata);
                grants_seen++;
                if (pending_grants.size() == 0) begin
                    $error("grant with none expected: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = pending_grants.pop_front();
                    if (got.status == ST_ALLOC) allocs_seen++;
                    if (got.status == ST_NO_FREE) nofree_seen++;
                    if (got.status == ST_CNT_ERR) errs_seen++;
                    if (got.slot !== want.slot) begin
                        $error("slot expected %0d actual %0d", want.slot, got.slot);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.fill_needed !== want.fill_needed) begin
                        $error("fill_needed expected %0d actual %0d",
                               want.fill_needed, got.fill_needed);
                        fail_count++;
                    end
                end
            end
            if (burst > 0) begin
                burst--;
                m_tready <= 1'b0;
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 15);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic test_reset_tags();
        // reset tags hit device 0 block 0 on the head of bucket 0
        send_request(KIND_ACQUIRE, 8'd0, 32'd0, 5'd0);
        send_request(KIND_ACQUIRE, 8'd0, 32'd0, 5'd0);
        send_request(KIND_ACQUIRE, 8'hff, 32'hffff_ffff, 5'd0);
        send_request(KIND_ACQUIRE, 8'h01, 32'd13, 5'd0);
        send_request(KIND_UNUSED, 8'hff, 32'hffff_ffff, 5'h1f);
    endtask

    task automatic test_count_edges();
        // drop at zero, add past saturation, a tag hit, then drop the count back to zero
        send_request(KIND_DROP_REF, 8'd0, 32'd0, 5'd3);
        send_request(KIND_DROP_REF, 8'hff, 32'hffff_ffff, 5'd31);
        for (int i = 0; i < 256; i++) send_request(KIND_ADD_REF, 8'd0, 32'd0, 5'd5);
        send_request(KIND_ACQUIRE, 8'd0, 32'd0, 5'd0);
        for (int i = 0; i < 255; i++) send_request(KIND_DROP_REF, 8'd0, 32'd0, 5'd5);
    endtask

    task automatic test_pool_exhaust();
        // take every free buffer, then keep asking after none is left
        for (int i = 0; i < POOL_SIZE + 2; i++)
            send_request(KIND_ACQUIRE, 8'h5a, 32'h1000 + 32'(i * 7), 5'd0);
        for (int i = 0; i < POOL_SIZE; i++) send_request(KIND_DROP_REF, 8'd0, 32'd0, 5'(i));
    endtask

    task automatic test_random_traffic(int count);
        kind_t k;
        logic [31:0] blk;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: k = KIND_ACQUIRE;
                5, 6:          k = KIND_ADD_REF;
                7, 8:          k = KIND_DROP_REF;
                default:       k = KIND_UNUSED;
            endcase
            // small block range for hits, sometimes the full range
            blk = ($urandom_range(0, 4) == 0) ? $urandom() : 32'($urandom_range(0, 60));
            send_request(k, 8'($urandom_range(0, 3)) | ($urandom_range(0, 7) == 0 ? 8'hfc : 8'h0),
                         blk, 5'($urandom_range(0, 31)));
        end
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        fail_count = 0;
        grants_seen = 0;
        allocs_seen = 0;
        nofree_seen = 0;
        errs_seen = 0;
        sink_stalls = 1'b0;
        source_gaps = 1'b0;
        pool_reset();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_tags();
        sink_stalls = 1'b1;
        source_gaps = 1'b1;
        test_count_edges();
        test_pool_exhaust();
        test_random_traffic(220);
        sink_stalls = 1'b0;
        source_gaps = 1'b0;
        test_random_traffic(100);

        while (pending_grants.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("covered %0d grants: %0d allocations, %0d no-free, %0d count errors",
                 grants_seen, allocs_seen, nofree_seen, errs_seen);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
